// ===== design/pcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the parabolic crossing finder.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CROSSINGS = 1'd1;

    localparam logic [COUNT_W-1:0] MAX_CROSSINGS_RESET = 8'd16;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_x;
        logic signed [DATA_W-1:0] sample_y;
        logic                     series_start;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] crossing_x;
        logic [COUNT_W-1:0]       crossing_count;
    } out_word_t;

endpackage

// ===== design/parabolic_crossing_finder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parabolic_crossing_finder_unit
// Three-sample parabolic zero-crossing interpolator with a serial root search.
// ----------------------------------------------------------------------------
// channel | signals                     | direction
// in      | in_valid in_stall in_word   | word in, stall out
// out     | out_valid out_stall out_word| word out, stall in
// cfg     | cfg_we cfg_index cfg_data   | write only
//
// a word without a crossing returns to idle after the check; a crossing runs the
// serial root search on the shared 53x18 multiply, which evaluates the polynomial
// in three steps per root bit; zero curvature skips the search.
// reset clears window, count and registers to their defaults.
// in_stall is high while a word is being worked or a result waits; a stall
// on out holds the result in the output state.
module parabolic_crossing_finder_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  pcf_pkg::in_word_t       in_word,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pcf_pkg::out_word_t      out_word,
    input  logic                    cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;
    localparam logic [2:0] S_OFF   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam int KW = FRAC_BITS;
    localparam int BW = $clog2(FRAC_BITS);
    localparam int YW = 35;                 // a2, b2 range
    localparam int UW = YW + KW + 2;        // a2*k + b2*2^F
    localparam int SW = UW + KW + 2;        // u*k + 2c*2^2F

    logic [2:0] state_reg, state_next;
    logic       dir_reg;
    logic [COUNT_W-1:0] max_reg, count_reg;
    logic [1:0] fill_reg;
    logic signed [DATA_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [DATA_W-1:0] xn_reg, yn_reg;
    logic signed [YW-1:0] a2_reg, b2_reg, c_reg;
    logic [KW-1:0] k_reg;
    logic [BW-1:0] bit_reg;
    logic signed [UW-1:0] u_reg;
    logic signed [SW-1:0] s_reg;
    logic signed [DATA_W+KW+1:0] prod_reg;
    out_word_t out_reg;

    // shared multiplier
    logic signed [UW-1:0]  mul_a;
    logic signed [KW+1:0]  mul_b;
    logic signed [UW+KW+1:0] mul_p;
    logic [KW-1:0] cand;
    logic signed [YW-1:0] ny0, ny1, ny2;
    logic signed [YW-1:0] a2_w;
    logic                 take;
    logic signed [DATA_W:0] dx;
    logic signed [DATA_W+1:0] sum;
    logic signed [DATA_W+KW+1:0] pneg;

    assign cand = k_reg | (KW'(1) << bit_reg);
    assign dx   = {x1_reg[DATA_W-1], x1_reg} - {x0_reg[DATA_W-1], x0_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL1: begin mul_a = UW'(a2_reg); mul_b = {2'b00, cand}; end
            S_MUL2: begin mul_a = u_reg;       mul_b = {2'b00, cand}; end
            S_OFF:  begin mul_a = UW'(dx);     mul_b = {2'b00, k_reg}; end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        ny0 = dir_reg ? -YW'(y0_reg) : YW'(y0_reg);
        ny1 = dir_reg ? -YW'(y1_reg) : YW'(y1_reg);
        ny2 = dir_reg ? -YW'(yn_reg) : YW'(yn_reg);
        a2_w = ny0 + ny2 - (ny1 <<< 1);
        take = (fill_reg == 2'd2) && (count_reg < max_reg) &&
               (ny0 > 0) && (ny1 >= 0) && (ny2 < 0);
        pneg = -prod_reg;
        if (!prod_reg[DATA_W+KW+1])
            sum = (DATA_W+2)'(x1_reg) + (DATA_W+2)'(prod_reg >>> FRAC_BITS);
        else
            sum = (DATA_W+2)'(x1_reg) - (DATA_W+2)'((pneg +
                  ((DATA_W+KW+2)'(1) <<< FRAC_BITS) - 1) >>> FRAC_BITS);
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CHECK;
            S_CHECK: state_next = !take ? S_IDLE : ((a2_w == 0) ? S_FIN : S_MUL1);
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_TEST;
            S_TEST:  state_next = (bit_reg == '0) ? S_OFF : S_MUL1;
            S_OFF:   state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dir_reg   <= 1'b0;
            max_reg   <= MAX_CROSSINGS_RESET;
            count_reg <= '0;
            fill_reg  <= '0;
            x0_reg <= '0; x1_reg <= '0; y0_reg <= '0; y1_reg <= '0;
            xn_reg <= '0; yn_reg <= '0;
            a2_reg <= '0; b2_reg <= '0; c_reg <= '0;
            k_reg <= '0; bit_reg <= '0;
            u_reg <= '0; s_reg <= '0; prod_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIRECTION:     dir_reg <= cfg_data[0];
                    REG_MAX_CROSSINGS: max_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && in_valid)
            begin
                xn_reg <= in_word.sample_x;
                yn_reg <= in_word.sample_y;
                if (in_word.series_start)
                begin
                    fill_reg  <= '0;
                    count_reg <= '0;
                end
            end
            if (state_reg == S_CHECK)
            begin
                if (fill_reg != 2'd2) fill_reg <= fill_reg + 2'd1;
                if (take)
                begin
                    a2_reg  <= a2_w;
                    b2_reg  <= ny2 - ny0;
                    c_reg   <= ny1;
                    k_reg   <= '0;
                    bit_reg <= BW'(FRAC_BITS - 1);
                    prod_reg <= '0;
                end
                else
                begin
                    x0_reg <= x1_reg; y0_reg <= y1_reg;
                    x1_reg <= xn_reg; y1_reg <= yn_reg;
                end
            end
            if (state_reg == S_MUL1)
                u_reg <= UW'(mul_p) + (UW'(b2_reg) <<< FRAC_BITS);
            if (state_reg == S_MUL2)
                s_reg <= SW'(mul_p) + (SW'(c_reg) <<< (2 * FRAC_BITS + 1));
            if (state_reg == S_TEST)
            begin
                if (!s_reg[SW-1]) k_reg <= cand;
                bit_reg <= bit_reg - BW'(1);
            end
            if (state_reg == S_OFF)
                prod_reg <= (DATA_W+KW+2)'(mul_p);
            if (state_reg == S_FIN)
            begin
                if (sum > (DATA_W+2)'(32'sh7fffffff))
                    out_reg.crossing_x <= 32'sh7fffffff;
                else if (sum < -(DATA_W+2)'(33'sh080000000))
                    out_reg.crossing_x <= 32'sh80000000;
                else
                    out_reg.crossing_x <= sum[DATA_W-1:0];
                out_reg.crossing_count <= count_reg + COUNT_W'(1);
                count_reg <= count_reg + COUNT_W'(1);
                x0_reg <= x1_reg; y0_reg <= y1_reg;
                x1_reg <= xn_reg; y1_reg <= yn_reg;
            end
        end
    end

    ap_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_FIN)
        else $error("result without finish");
    ap_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result waits");
    ap_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.crossing_count != '0)
        else $error("zero crossing count");
endmodule
